// ----- src/mhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// Max-heap priority queue package
// Shared types, request codes and constants for the priority queue cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

   // Width of one stored value.
   localparam int DATA_W = 32;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [1:0]               req_code_type;

   // Request codes.
   localparam req_code_type REQ_PUSH = 2'd0;
   localparam req_code_type REQ_POP  = 2'd1;
   localparam req_code_type REQ_PEEK = 2'd2;

   // Maximum reported when the queue holds nothing.
   localparam data_type EMPTY_MAX = '1;

   // Data handed from a cell to the next (lower priority) cell.
   typedef struct packed {
      logic     valid;
      data_type value;
      logic     gt;
   } down_link_type;

   // Data handed from a cell to the previous (higher priority) cell.
   typedef struct packed {
      logic     valid;
      data_type value;
   } up_link_type;

   // Command broadcast to every cell.
   typedef struct packed {
      logic     push;
      logic     pop;
      data_type value;
   } cell_cmd_type;

endpackage

`default_nettype wire

// ----- src/mhpq_if.sv -----
// ----------------------------------------------------------------------------
// Max-heap priority queue channels
// Valid/ready interfaces for the request and response channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface mhpq_req_if;
   logic                   valid;
   logic                   ready;
   mhpq_pkg::req_code_type req_type;
   mhpq_pkg::data_type     push_value;

   modport source (output valid, output req_type, output push_value, input ready);
   modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface mhpq_rsp_if #(
   parameter int COUNT_W = 11
);
   logic                 valid;
   logic                 ready;
   mhpq_pkg::data_type   max_value;
   logic [COUNT_W-1:0]   entry_count;
   logic                 is_empty;
   logic                 push_rejected;

   modport source (output valid, output max_value, output entry_count,
                   output is_empty, output push_rejected, input ready);
   modport sink   (input valid, input max_value, input entry_count,
                   input is_empty, input push_rejected, output ready);
endinterface

`default_nettype wire

// ----- src/max_heap_priority_queue.sv -----
// ----------------------------------------------------------------------------
// Max-heap priority queue
// Priority queue of signed 32-bit values built as a sorted chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req channel: req_type selects push, pop or peek,
//   and push_value carries the value to insert. Code 3 behaves as a peek.
//   Every accepted request yields exactly one response on the rsp channel
//   with the maximum after the request (all ones when empty), the entry
//   count, an empty flag and a flag for a push dropped because the queue
//   already holds CAPACITY values. A pop on an empty queue changes nothing.
//   The response is registered and valid in the cycle after acceptance.
//   Throughput is one request per cycle while rsp is not stalled; every
//   cell of the chain compares against the broadcast value and shifts in
//   the same cycle. When the receiver stalls, the response register holds
//   its content and req.ready stays low until the response is taken.
//   Reset clears the occupancy bit of every cell and the count;
//   no clearing pass is needed and requests are taken right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue #(
   parameter int CAPACITY = 1024
) (
   input wire logic clock,
   input wire logic reset,
   mhpq_req_if.sink   req,
   mhpq_rsp_if.source rsp
);

   localparam int COUNT_W = $clog2(CAPACITY + 1);

   mhpq_pkg::down_link_type dlink [CAPACITY+1];
   mhpq_pkg::up_link_type   ulink [CAPACITY+1];
   mhpq_pkg::cell_cmd_type  cmd;

   logic               accept;
   logic               full;
   logic               rsp_valid_ff;
   mhpq_pkg::data_type max_ff;
   mhpq_pkg::data_type max_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               rejected_ff;
   logic               rejected_in;
   logic               do_push;
   logic               do_pop;
   mhpq_pkg::data_type cur_max;

   // Chain boundaries: the head sees a full slot that never ranks below,
   // the tail sees an empty slot behind it.
   assign dlink[0]        = '{valid: 1'b1, value: '0, gt: 1'b0};
   assign ulink[CAPACITY] = '0;

   // Row of cells, head first.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      mhpq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .from_prev (dlink[i]),
         .from_next (ulink[i+1]),
         .to_next   (dlink[i+1]),
         .to_prev   (ulink[i])
      );
   end

   // The last cell is occupied exactly when the queue is full.
   assign full = dlink[CAPACITY].valid;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign cur_max = ulink[0].valid ? ulink[0].value : mhpq_pkg::EMPTY_MAX;

   // Decode the request and work out the state seen after it.
   always_comb begin
      do_push     = 1'b0;
      do_pop      = 1'b0;
      rejected_in = 1'b0;
      count_in    = count_ff;
      max_in      = cur_max;
      case (req.req_type)
         mhpq_pkg::REQ_PUSH: begin
            if (full) begin
               rejected_in = 1'b1;
            end else begin
               do_push  = 1'b1;
               count_in = count_ff + COUNT_W'(1);
               if (!ulink[0].valid || (req.push_value > ulink[0].value)) begin
                  max_in = req.push_value;
               end
            end
         end
         mhpq_pkg::REQ_POP: begin
            if (ulink[0].valid) begin
               do_pop   = 1'b1;
               count_in = count_ff - COUNT_W'(1);
               max_in   = ulink[1].valid ? ulink[1].value : mhpq_pkg::EMPTY_MAX;
            end
         end
         mhpq_pkg::REQ_PEEK: begin
            max_in = cur_max;
         end
         default: begin
            max_in = cur_max;
         end
      endcase
   end

   assign cmd.push  = accept && do_push;
   assign cmd.pop   = accept && do_pop;
   assign cmd.value = req.push_value;

   // Response valid and entry count.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (accept) begin
            rsp_valid_ff <= 1'b1;
            count_ff     <= count_in;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         max_ff      <= max_in;
         rejected_ff <= rejected_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.max_value     = max_ff;
   assign rsp.entry_count   = count_ff;
   assign rsp.is_empty      = (count_ff == '0);
   assign rsp.push_rejected = rejected_ff;

endmodule

`default_nettype wire

// ----- src/mhpq_cell.sv -----
// ----------------------------------------------------------------------------
// Max-heap priority queue cell
// One slot of the sorted cell chain: holds a value and shifts it on push/pop.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire mhpq_pkg::cell_cmd_type  cmd,
   input  wire mhpq_pkg::down_link_type from_prev,
   input  wire mhpq_pkg::up_link_type   from_next,
   output mhpq_pkg::down_link_type      to_next,
   output mhpq_pkg::up_link_type        to_prev
);

   logic               valid_ff;
   logic               valid_in;
   mhpq_pkg::data_type value_ff;
   mhpq_pkg::data_type value_in;
   logic               gt;

   // The new value ranks above this slot when the slot is empty or smaller.
   // Equal values stay ahead of the new one.
   assign gt = !valid_ff || (cmd.value > value_ff);

   // On push, the first slot that ranks below takes the new value and every
   // slot after it takes its predecessor's content. On pop, all shift up.
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (cmd.push && gt) begin
         if (!from_prev.gt) begin
            valid_in = 1'b1;
            value_in = cmd.value;
         end else begin
            valid_in = from_prev.valid;
            value_in = from_prev.value;
         end
      end else if (cmd.pop) begin
         valid_in = from_next.valid;
         value_in = from_next.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign to_next.valid = valid_ff;
   assign to_next.value = value_ff;
   assign to_next.gt    = gt;
   assign to_prev.valid = valid_ff;
   assign to_prev.value = value_ff;

endmodule

`default_nettype wire

// ----- src/mhpq_checker.sv -----
// ----------------------------------------------------------------------------
// Max-heap priority queue checker
// Port-level assertions on the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_checker #(
   parameter int CAPACITY = 1024,
   parameter int COUNT_W  = $clog2(CAPACITY + 1)
) (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire mhpq_pkg::data_type max_value,
   input wire logic [COUNT_W-1:0] entry_count,
   input wire logic               is_empty,
   input wire logic               push_rejected
);

   // Every accepted request produces a response in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("response missing after accepted request");

   // A stalled response stays valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   // The empty flag agrees with the count and the reported maximum.
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((is_empty == (entry_count == '0))
                     && (!is_empty || (max_value == mhpq_pkg::EMPTY_MAX))))
      else $error("empty flag inconsistent with count or maximum");

   // A push is only dropped when the queue is full.
   a_reject_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && push_rejected) |-> (entry_count == COUNT_W'(CAPACITY)))
      else $error("push rejected while queue not full");

endmodule

bind max_heap_priority_queue mhpq_checker #(
   .CAPACITY (CAPACITY),
   .COUNT_W  (COUNT_W)
) u_mhpq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .max_value     (rsp.max_value),
   .entry_count   (rsp.entry_count),
   .is_empty      (rsp.is_empty),
   .push_rejected (rsp.push_rejected)
);

`default_nettype wire
